/* rtl/ibsp_pkg.sv */
// Shared types and constants for the image block stream packetizer.
// Holds the channel payload structs, the configuration struct and the job record
// passed from the front end to the back end. No dependencies.
package ibsp_pkg;

  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic [63:0] frame_time;
  } pkt_in_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_packet;
    logic       last_of_run;
  } pkt_out_t;

  typedef struct packed {
    logic [15:0] status_word;
    logic [31:0] pixel_format_code;
    logic [12:0] block_width;
    logic [12:0] block_height;
    logic [12:0] payload_bytes;
  } cfg_t;

  // One classified pixel: which packets it opens or closes, and the ids to use.
  typedef struct packed {
    logic        leader;
    logic        hdr;
    logic        trailer;
    logic        eop_pix;
    logic [7:0]  pixel_byte;
    logic [63:0] frame_time;
    logic [15:0] blk_num;
    logic [23:0] pay_id;
    logic [23:0] trl_id;
  } job_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_STATUS  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIXFMT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD = 3'd4;

  localparam logic [12:0] MAX_SIDE    = 13'd4096;
  localparam logic [12:0] MAX_PAYLOAD = 13'd8184;

  localparam logic [7:0] FMT_LEADER  = 8'd1;
  localparam logic [7:0] FMT_TRAILER = 8'd2;
  localparam logic [7:0] FMT_PAYLOAD = 8'd3;

endpackage

/* rtl/image_block_stream_packetizer_core.sv */
// Top level of the image block stream packetizer: configuration registers,
// front end, job queue and back end. Depends on ibsp_pkg and the ibsp_* modules.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-----------------------------
//  pixel in | input     | push / full                   | in_data_i  (pkt_in_t)
//  stream   | output    | empty / pop                   | out_data_o (pkt_out_t)
//  config   | input     | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Rate: the back end emits one stream byte per cycle unless pop stalls it; a pixel
// yields its own byte, plus a payload header if it opens a packet, the leader if it
// is the first of a block and the trailer if it is the last. The front end takes one
// pixel per cycle until the job queue (QueueDepth entries) fills.
// Reset: counters start at block id 0, packet id 0; config takes its reset values.
// Stalls: pop low holds the output register; the back end then holds and the queue
// fills, and full rises until the back end drains a job.
module image_block_stream_packetizer_core import ibsp_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pkt_in_t            in_data_i,
  output logic               empty,
  input  logic               pop,
  output pkt_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic q_push, q_full, q_valid, q_pop;
  job_t q_wdata, q_rdata;

  // Config writes are always taken; user must write only while idle; not checked.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STATUS:  cfg_d.status_word       = cfg_data_i[15:0];
        CFG_PIXFMT:  cfg_d.pixel_format_code = cfg_data_i;
        CFG_WIDTH:   cfg_d.block_width       = cfg_data_i[12:0];
        CFG_HEIGHT:  cfg_d.block_height      = cfg_data_i[12:0];
        CFG_PAYLOAD: cfg_d.payload_bytes     = cfg_data_i[12:0];
        default:     cfg_d = cfg_q;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.status_word       <= '0;
      cfg_q.pixel_format_code <= '0;
      cfg_q.block_width       <= 13'd2048;
      cfg_q.block_height      <= 13'd128;
      cfg_q.payload_bytes     <= 13'd2968;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full = q_full;

  // Classify each accepted pixel into a job record.
  ibsp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  // Decouple classification from serialization.
  ibsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  // Serialize jobs into the byte stream, one transfer per cycle while pop keeps up.
  ibsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_valid),
    .head_i       (q_rdata),
    .head_pop_o   (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_data_o   (out_data_o)
  );

endmodule

/* rtl/ibsp_front.sv */
// Front end of the packetizer: accepts pixel bytes and classifies each one.
// Tracks block, packet and byte counters; depends on ibsp_pkg.
module ibsp_front import ibsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pkt_in_t in_data_i,
  input  cfg_t    cfg_i,
  input  logic    q_full_i,
  output logic    q_push_o,
  output job_t    q_data_o
);

  logic [15:0] block_q, block_d;
  logic [23:0] pkt_q, pkt_d;
  logic [23:0] pix_q, pix_d;
  logic [13:0] bytes_q, bytes_d;

  logic [12:0] side_w, side_h, plen;
  logic [25:0] prod;
  logic [24:0] total;
  logic        leader, hdr, last_pix, pkt_end, accept;
  logic [23:0] pn_base, pn_pay, pn_trl;
  logic [13:0] bd;

  always_comb begin
    side_w = (cfg_i.block_width == '0) ? 13'd1 :
             (cfg_i.block_width > MAX_SIDE) ? MAX_SIDE : cfg_i.block_width;
    side_h = (cfg_i.block_height == '0) ? 13'd1 :
             (cfg_i.block_height > MAX_SIDE) ? MAX_SIDE : cfg_i.block_height;
    plen   = (cfg_i.payload_bytes == '0) ? 13'd1 :
             (cfg_i.payload_bytes > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_i.payload_bytes;
    prod   = {13'd0, side_w} * {13'd0, side_h};
    total  = (prod[24:0] < 25'd2) ? 25'd2 : prod[24:0];

    accept   = push_i && !q_full_i;
    leader   = (pix_q == '0);
    pn_base  = leader ? '0 : pkt_q;
    bd       = leader ? '0 : bytes_q;
    hdr      = (bd == '0);
    pn_pay   = hdr ? pn_base + 24'd1 : pn_base;
    pn_trl   = pn_pay + 24'd1;
    last_pix = ({1'b0, pix_q} + 25'd1) >= total;
    pkt_end  = last_pix || ((bd + 14'd1) >= {1'b0, plen});

    block_d = block_q;
    pkt_d   = pkt_q;
    pix_d   = pix_q;
    bytes_d = bytes_q;
    if (accept) begin
      if (last_pix) begin
        pix_d   = '0;
        bytes_d = '0;
        pkt_d   = pn_trl;
        block_d = (block_q != 16'hffff) ? block_q + 16'd1 : 16'd1;
      end else begin
        pix_d   = pix_q + 24'd1;
        bytes_d = pkt_end ? '0 : bd + 14'd1;
        pkt_d   = pn_pay;
      end
    end

    q_push_o            = accept;
    q_data_o.leader     = leader;
    q_data_o.hdr        = hdr;
    q_data_o.trailer    = last_pix;
    q_data_o.eop_pix    = pkt_end;
    q_data_o.pixel_byte = in_data_i.pixel_byte;
    q_data_o.frame_time = in_data_i.frame_time;
    q_data_o.blk_num    = block_q;
    q_data_o.pay_id     = pn_pay;
    q_data_o.trl_id     = pn_trl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q <= '0;
      pkt_q   <= '0;
      pix_q   <= '0;
      bytes_q <= '0;
    end else begin
      block_q <= block_d;
      pkt_q   <= pkt_d;
      pix_q   <= pix_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

/* rtl/ibsp_queue.sv */
// Short job queue between the front end and the back end.
// Register-based FIFO of job records; depends on ibsp_pkg.
module ibsp_queue import ibsp_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    valid_o = (cnt_q != '0);
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    data_o  = mem_q[rd_q];
    wr_d    = wr_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/ibsp_back.sv */
// Back end of the packetizer: serializes one job into stream bytes.
// Sequences leader, payload header, pixel and trailer; registered output; uses ibsp_pkg.
module ibsp_back import ibsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     head_valid_i,
  input  job_t     head_i,
  output logic     head_pop_o,
  output logic     empty_o,
  input  logic     pop_i,
  output pkt_out_t out_data_o
);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_PHDR = 2'd1;
  localparam logic [1:0] PH_PIX  = 2'd2;
  localparam logic [1:0] PH_TRL  = 2'd3;

  localparam logic [5:0] LEAD_LAST = 6'd43;
  localparam logic [5:0] HDR_LAST  = 6'd7;
  localparam logic [5:0] TRL_LAST  = 6'd15;

  logic       active_q, active_d;
  logic [1:0] phase_q, phase_d, phase;
  logic [5:0] idx_q, idx_d;
  pkt_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic       advance, emit, ph_last, job_last;
  logic [7:0] byte_v;
  logic       eop;
  logic [5:0] tsel;
  logic [63:0] tshift;

  function automatic logic [7:0] hdr_byte(input logic [15:0] st, input logic [15:0] bn,
                                          input logic [7:0] fmt, input logic [23:0] pn,
                                          input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = st[15:8];
      3'd1:    b = st[7:0];
      3'd2:    b = bn[15:8];
      3'd3:    b = bn[7:0];
      3'd4:    b = fmt;
      3'd5:    b = pn[23:16];
      3'd6:    b = pn[15:8];
      default: b = pn[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  always_comb begin
    advance = !out_valid_q || pop_i;
    emit    = head_valid_i && advance;
    if (active_q) phase = phase_q;
    else if (head_i.leader) phase = PH_LEAD;
    else if (head_i.hdr) phase = PH_PHDR;
    else phase = PH_PIX;

    // Timestamp bytes sit at leader offsets 12..19, high byte first.
    tsel   = 6'd19 - idx_q;
    tshift = head_i.frame_time >> {tsel[2:0], 3'b000};

    byte_v   = '0;
    eop      = 1'b0;
    ph_last  = 1'b0;
    job_last = 1'b0;
    unique case (phase)
      PH_LEAD: begin
        ph_last = (idx_q == LEAD_LAST);
        eop     = ph_last;
        case (idx_q) inside
          [6'd0:6'd7]:   byte_v = hdr_byte(cfg_i.status_word, head_i.blk_num,
                                           FMT_LEADER, '0, idx_q[2:0]);
          [6'd8:6'd11]:  byte_v = word_byte(32'd1, idx_q[1:0]);
          [6'd12:6'd19]: byte_v = tshift[7:0];
          [6'd20:6'd23]: byte_v = word_byte(cfg_i.pixel_format_code, idx_q[1:0]);
          [6'd24:6'd27]: byte_v = word_byte({19'd0, cfg_i.block_width}, idx_q[1:0]);
          [6'd28:6'd31]: byte_v = word_byte({19'd0, cfg_i.block_height}, idx_q[1:0]);
          default:       byte_v = '0;
        endcase
      end
      PH_PHDR: begin
        ph_last = (idx_q == HDR_LAST);
        byte_v  = hdr_byte(cfg_i.status_word, head_i.blk_num, FMT_PAYLOAD,
                           head_i.pay_id, idx_q[2:0]);
      end
      PH_PIX: begin
        ph_last  = 1'b1;
        byte_v   = head_i.pixel_byte;
        eop      = head_i.eop_pix;
        job_last = !head_i.trailer;
      end
      PH_TRL: begin
        ph_last  = (idx_q == TRL_LAST);
        eop      = ph_last;
        job_last = ph_last;
        case (idx_q) inside
          [6'd0:6'd7]:  byte_v = hdr_byte(cfg_i.status_word, head_i.blk_num,
                                          FMT_TRAILER, head_i.trl_id, idx_q[2:0]);
          [6'd8:6'd11]: byte_v = word_byte(32'd1, idx_q[1:0]);
          default:      byte_v = word_byte({19'd0, cfg_i.block_height}, idx_q[1:0]);
        endcase
      end
      default: begin
        byte_v = '0;
      end
    endcase

    active_d    = active_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    head_pop_o  = 1'b0;
    if (emit) begin
      out_d.stream_byte   = byte_v;
      out_d.end_of_packet = eop;
      out_d.last_of_run   = job_last;
      out_valid_d         = 1'b1;
      if (job_last) begin
        active_d   = 1'b0;
        idx_d      = '0;
        head_pop_o = 1'b1;
      end else if (ph_last) begin
        active_d = 1'b1;
        idx_d    = '0;
        // Advance to the next section of this job.
        unique case (phase)
          PH_LEAD: phase_d = head_i.hdr ? PH_PHDR : PH_PIX;
          PH_PHDR: phase_d = PH_PIX;
          default: phase_d = PH_TRL;
        endcase
      end else begin
        active_d = 1'b1;
        phase_d  = phase;
        idx_d    = idx_q + 6'd1;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end

    empty_o    = !out_valid_q;
    out_data_o = out_q;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      phase_q     <= PH_LEAD;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* test/testbench.sv */
// Self-checking testbench for image_block_stream_packetizer_core.
// Predicts the leader, payload and trailer byte stream for every pixel transfer and
// checks it against the block output; depends on ibsp_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
  import ibsp_pkg::*;

  localparam int unsigned IdleLimit   = 4000;  // cycles without any transfer
  localparam int unsigned TargetItems = 320;
  localparam int unsigned DrainCycles = 64;    // extra wait after the last drain
  localparam logic [CfgIdxW-1:0] CFG_SPARE_FIRST = CFG_PAYLOAD + 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LAST  = '1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  pkt_in_t             in_data_i   = '0;
  logic                empty;
  logic                pop         = 1'b0;
  pkt_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [31:0]         cfg_data_i  = '0;

  image_block_stream_packetizer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Stream predictor: shadow registers and framing counters
  // ---------------------------------------------------------------------------
  cfg_t        shadow_cfg = '{status_word: 16'd0, pixel_format_code: 32'd0,
                              block_width: 13'd2048, block_height: 13'd128,
                              payload_bytes: 13'd2968};
  logic [15:0] blk_id   = '0;
  logic [23:0] pkt_id   = '0;
  int unsigned pix_cnt  = 0;   // pixels already sent in the current block
  int unsigned byte_cnt = 0;   // pixel bytes already sent in the current packet

  pkt_out_t    run_q[$];          // stream bytes caused by one pixel
  pkt_out_t    want_stream_q[$];  // stream bytes still to come out of the block
  pkt_in_t     pixel_q[$];        // pixels waiting for the driver

  int unsigned mismatch_cnt = 0;
  int unsigned result_idx   = 0;

  function automatic void add_byte(logic [7:0] b, logic eop);
    run_q.push_back({b, eop, 1'b0});
  endfunction

  function automatic void add_word32(logic [31:0] w, logic eop_last);
    add_byte(w[31:24], 1'b0);
    add_byte(w[23:16], 1'b0);
    add_byte(w[15:8],  1'b0);
    add_byte(w[7:0],   eop_last);
  endfunction

  // Common 8-byte header: status, block id, packet format, 24-bit packet id.
  function automatic void add_header(logic [7:0] fmt);
    add_byte(shadow_cfg.status_word[15:8], 1'b0);
    add_byte(shadow_cfg.status_word[7:0],  1'b0);
    add_byte(blk_id[15:8], 1'b0);
    add_byte(blk_id[7:0],  1'b0);
    add_byte(fmt, 1'b0);
    add_byte(pkt_id[23:16], 1'b0);
    add_byte(pkt_id[15:8],  1'b0);
    add_byte(pkt_id[7:0],   1'b0);
  endfunction

  function automatic int unsigned side_len(logic [12:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return 32'(MAX_SIDE);
    return 32'(v);
  endfunction

  // Work out every stream byte that one accepted pixel causes and queue them.
  function automatic void packetize_pixel(pkt_in_t px);
    int unsigned total;
    int unsigned plen;
    logic        last_pix;
    logic        pkt_end;
    pkt_out_t    tail;

    // Limits follow the registers as they stand now, so a shrink mid-block
    // closes the packet or block on this pixel.
    total = side_len(shadow_cfg.block_width) * side_len(shadow_cfg.block_height);
    if (total < 2) total = 2;   // a block is never a single pixel
    plen = 32'(shadow_cfg.payload_bytes);
    if (plen < 1) plen = 1;
    if (plen > 32'(MAX_PAYLOAD)) plen = 32'(MAX_PAYLOAD);
    run_q.delete();

    if (pix_cnt == 0) begin
      // Leader: packet id restarts at zero with every block.
      pkt_id   = '0;
      byte_cnt = 0;
      add_header(FMT_LEADER);
      add_word32(32'd1, 1'b0);
      add_word32(px.frame_time[63:32], 1'b0);
      add_word32(px.frame_time[31:0], 1'b0);
      add_word32(shadow_cfg.pixel_format_code, 1'b0);
      add_word32({19'd0, shadow_cfg.block_width}, 1'b0);
      add_word32({19'd0, shadow_cfg.block_height}, 1'b0);
      add_word32(32'd0, 1'b0);
      add_word32(32'd0, 1'b0);
      add_word32(32'd0, 1'b1);
    end

    if (byte_cnt == 0) begin
      pkt_id = pkt_id + 24'd1;
      add_header(FMT_PAYLOAD);
    end

    last_pix = (pix_cnt + 1) >= total;
    pkt_end  = last_pix || ((byte_cnt + 1) >= plen);
    add_byte(px.pixel_byte, pkt_end);
    pix_cnt++;
    byte_cnt = pkt_end ? 0 : byte_cnt + 1;

    if (last_pix) begin
      pkt_id = pkt_id + 24'd1;
      add_header(FMT_TRAILER);
      add_word32(32'd1, 1'b0);
      add_word32({19'd0, shadow_cfg.block_height}, 1'b1);
      // Block id skips zero when it wraps.
      blk_id   = (blk_id != 16'hFFFF) ? blk_id + 16'd1 : 16'd1;
      pix_cnt  = 0;
      byte_cnt = 0;
    end

    tail = run_q.pop_back();
    tail.last_of_run = 1'b1;
    run_q.push_back(tail);
    foreach (run_q[i]) want_stream_q.push_back(run_q[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (push && !full) packetize_pixel(in_data_i);
    // Only touch the channel once the current transfer has gone through.
    if (!push || !full) begin
      if (gap_left != 0) begin
        push     <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        push      <= 1'b1;
        in_data_i <= pixel_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream monitor: pop follows a rate that changes each time stall_tick wraps
  // ---------------------------------------------------------------------------
  logic [5:0]  stall_tick = '0;
  int unsigned pop_pct    = 100;
  pkt_out_t    want;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) begin
      case ($urandom_range(0, 3))
        0:       pop_pct <= 100;
        1:       pop_pct <= 75;
        2:       pop_pct <= 50;
        default: pop_pct <= 20;
      endcase
    end
    pop <= ($urandom_range(0, 99) < pop_pct);

    if (rst_ni && !empty && pop) begin
      if (want_stream_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected (byte %02h)",
                                  result_idx, out_data_o.stream_byte));
      end else begin
        want = want_stream_q.pop_front();
        if (out_data_o.stream_byte !== want.stream_byte)
          report_mismatch($sformatf("result %0d stream_byte %02h, expected %02h",
                                    result_idx, out_data_o.stream_byte, want.stream_byte));
        if (out_data_o.end_of_packet !== want.end_of_packet)
          report_mismatch($sformatf("result %0d end_of_packet %b, expected %b",
                                    result_idx, out_data_o.end_of_packet,
                                    want.end_of_packet));
        if (out_data_o.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("result %0d last_of_run %b, expected %b",
                                    result_idx, out_data_o.last_of_run, want.last_of_run));
      end
      result_idx++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no transfer of any kind happens for too long
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((push && !full) || (!empty && pop) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL image_block_stream_packetizer_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: configure while idle, then hand pixels to the driver
  // ---------------------------------------------------------------------------

  // Hold until the driver is empty and every predicted byte has come out.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || push || want_stream_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Leave valid high: the caller drops it after its last write so that
  // back-to-back writes never lower and raise valid in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_STATUS:  shadow_cfg.status_word       = val[15:0];
      CFG_PIXFMT:  shadow_cfg.pixel_format_code = val;
      CFG_WIDTH:   shadow_cfg.block_width       = val[12:0];
      CFG_HEIGHT:  shadow_cfg.block_height      = val[12:0];
      CFG_PAYLOAD: shadow_cfg.payload_bytes     = val[12:0];
      default: ;
    endcase
  endtask

  task automatic queue_random(input int unsigned n);
    pkt_in_t px;
    repeat (n) begin
      px.pixel_byte = 8'($urandom_range(0, 255));
      px.frame_time = {$urandom(), $urandom()};
      pixel_q.push_back(px);
    end
  endtask

  // Mostly tiny sides; now and then zero, the saturation point or beyond it.
  // Upper data bits are random: only the low 13 bits should matter.
  function automatic logic [31:0] pick_side();
    logic [31:0] low;
    case ($urandom_range(0, 19))
      0:       low = 32'd0;
      1:       low = 32'h1FFF;
      2:       low = {19'd0, MAX_SIDE};
      default: low = $urandom_range(1, 6);
    endcase
    return ($urandom() & 32'hFFFF_E000) | low;
  endfunction

  function automatic logic [31:0] pick_payload();
    logic [31:0] low;
    case ($urandom_range(0, 15))
      0:       low = 32'd0;
      1:       low = 32'h1FFF;
      2:       low = {19'd0, MAX_PAYLOAD};
      3:       low = {19'd0, MAX_PAYLOAD} + 32'd1;
      default: low = $urandom_range(1, 8);
    endcase
    return ($urandom() & 32'hFFFF_E000) | low;
  endfunction

  initial begin
    int unsigned queued;
    int unsigned n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset configuration: a long block, left open on purpose.
    pixel_q.push_back('{pixel_byte: 8'h00, frame_time: 64'h0});
    pixel_q.push_back('{pixel_byte: 8'hFF, frame_time: '1});
    pixel_q.push_back('{pixel_byte: 8'h5A, frame_time: 64'h0123_4567_89AB_CDEF});
    queued = 3;

    // Smallest block and one-byte payloads with all-ones fields; the shrink
    // also closes the open block on its next pixel.
    wait_idle();
    write_reg(CFG_STATUS, 32'hFFFF_FFFF);
    write_reg(CFG_PIXFMT, 32'hFFFF_FFFF);
    write_reg(CFG_WIDTH, 32'd1);
    write_reg(CFG_HEIGHT, 32'd1);
    write_reg(CFG_PAYLOAD, 32'd1);
    cfg_valid_i <= 1'b0;
    pixel_q.push_back('{pixel_byte: 8'hFF, frame_time: '1});
    pixel_q.push_back('{pixel_byte: 8'h00, frame_time: 64'h0});
    queue_random(2);
    queued += 4;

    // Zero sizes and zero payload saturate up to their minimum.
    wait_idle();
    write_reg(CFG_STATUS, 32'h0);
    write_reg(CFG_PIXFMT, 32'h0);
    write_reg(CFG_WIDTH, 32'hFFFF_E000);
    write_reg(CFG_HEIGHT, 32'h0);
    write_reg(CFG_PAYLOAD, 32'h0);
    cfg_valid_i <= 1'b0;
    queue_random(4);
    queued += 4;

    // 3x2 blocks, 4-byte payloads: the open block ends in a full and a short packet.
    wait_idle();
    write_reg(CFG_STATUS, 32'h0000_A55A);
    write_reg(CFG_WIDTH, 32'hFFFF_E003);
    write_reg(CFG_HEIGHT, 32'd2);
    write_reg(CFG_PAYLOAD, 32'd4);
    cfg_valid_i <= 1'b0;
    queue_random(6);
    queued += 6;

    // Out-of-range sizes and payload; the block stays open.
    wait_idle();
    write_reg(CFG_WIDTH, 32'h1FFF);
    write_reg(CFG_HEIGHT, 32'h1FFF);
    write_reg(CFG_PAYLOAD, 32'h1FFF);
    cfg_valid_i <= 1'b0;
    queue_random(5);
    queued += 5;

    // Shrink mid-block and mid-packet: the next pixel ends both.
    wait_idle();
    write_reg(CFG_WIDTH, 32'd2);
    write_reg(CFG_HEIGHT, 32'd1);
    write_reg(CFG_PAYLOAD, 32'd2);
    cfg_valid_i <= 1'b0;
    queue_random(3);
    queued += 3;

    // Random phases; each boundary also makes the sender wait for a full drain.
    while (queued < TargetItems) begin
      wait_idle();
      if ($urandom_range(0, 1) == 0) write_reg(CFG_STATUS, $urandom());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_PIXFMT, $urandom());
      if ($urandom_range(0, 1) == 0) write_reg(CFG_WIDTH, pick_side());
      if ($urandom_range(0, 1) == 0) write_reg(CFG_HEIGHT, pick_side());
      if ($urandom_range(0, 1) == 0) write_reg(CFG_PAYLOAD, pick_payload());
      if ($urandom_range(0, 4) == 0)
        write_reg(CfgIdxW'($urandom_range(32'(CFG_SPARE_FIRST), 32'(CFG_SPARE_LAST))),
                  $urandom());
      cfg_valid_i <= 1'b0;
      n = $urandom_range(6, 40);
      queue_random(n);
      queued += n;
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && want_stream_q.size() == 0) begin
      $display("PASS image_block_stream_packetizer_core");
    end else begin
      $display("FAIL image_block_stream_packetizer_core");
    end
    $finish;
  end

endmodule

/* image_block_stream_packetizer_core.f */
rtl/ibsp_pkg.sv
rtl/ibsp_front.sv
rtl/ibsp_queue.sv
rtl/ibsp_back.sv
rtl/image_block_stream_packetizer_core.sv
test/testbench.sv
